// ===== rtl/core/vrp_pkg.sv =====
// Shared types, codes and address decode for the video register port.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

  // Item commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLAGS = 2'd2;

  // Register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Memory targets
  localparam logic [1:0] TGT_NONE = 2'd0;  // pattern area, not stored here
  localparam logic [1:0] TGT_NT   = 2'd1;
  localparam logic [1:0] TGT_PAL  = 2'd2;
  localparam logic [1:0] TGT_OAM  = 2'd3;

  localparam int NT_AW  = 11;
  localparam int PAL_AW = 5;
  localparam int OAM_AW = 8;
  localparam int VA_W   = 15;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [1:0]       tgt;
    logic [NT_AW-1:0] idx;
    logic [7:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]       tgt;
    logic [NT_AW-1:0] idx;
  } vmap_t;

  typedef struct packed {
    logic [7:0]      rdata;
    logic [VA_W-1:0] vaddr;
    logic [2:0]      fine_x;
  } res_t;

  // Map the low 14 bits of the video address onto a memory and an entry.
  function automatic vmap_t vram_map(input logic [VA_W-1:0] addr, input logic mirror);
    logic [PAL_AW-1:0] p;
    vmap_t             m;
    p = addr[PAL_AW-1:0];
    // backdrop entries of the sprite palettes fold onto the tile palettes
    if (p[4] && (p[1:0] == 2'b00)) p[4] = 1'b0;
    if (!addr[13]) begin
      m.tgt = TGT_NONE;
      m.idx = '0;
    end else if (addr[13:8] == 6'h3F) begin
      m.tgt = TGT_PAL;
      m.idx = {{(NT_AW-PAL_AW){1'b0}}, p};
    end else begin
      m.tgt = TGT_NT;
      m.idx = {(mirror ? addr[11] : addr[10]), addr[9:0]};
    end
    return m;
  endfunction

  function automatic logic [VA_W-1:0] step_addr(input logic [VA_W-1:0] addr,
                                               input logic inc32);
    return addr + (inc32 ? VA_W'(32) : VA_W'(1));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vrp_mem.sv =====
// Nametable, palette and sprite attribute memories with a clearing sweep.
// Depends on vrp_pkg for the request type and target codes.
`timescale 1ns / 1ps
`default_nettype none

module vrp_mem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vrp_pkg::mem_req_t req,
  output logic [7:0]             rdata,
  output logic                   clearing
);
  import vrp_pkg::*;

  logic [7:0] nt_mem  [2**NT_AW];
  logic [7:0] pal_mem [2**PAL_AW];
  logic [7:0] oam_mem [2**OAM_AW];

  logic [NT_AW-1:0] clr_cnt;
  logic             clr_busy;
  logic [7:0]       nt_q, pal_q, oam_q;
  logic [1:0]       tgt_q;

  // sweep every entry to zero after reset, one address per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) clr_busy <= 1'b0;
    end
  end

  assign clearing = clr_busy;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      nt_mem[clr_cnt] <= 8'd0;
    end else if (req.wr && (req.tgt == TGT_NT)) begin
      nt_mem[req.idx] <= req.wdata;
    end
    if (req.rd) nt_q <= nt_mem[req.idx];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      pal_mem[clr_cnt[PAL_AW-1:0]] <= 8'd0;
    end else if (req.wr && (req.tgt == TGT_PAL)) begin
      pal_mem[req.idx[PAL_AW-1:0]] <= req.wdata;
    end
    if (req.rd) pal_q <= pal_mem[req.idx[PAL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      oam_mem[clr_cnt[OAM_AW-1:0]] <= 8'd0;
    end else if (req.wr && (req.tgt == TGT_OAM)) begin
      oam_mem[req.idx[OAM_AW-1:0]] <= req.wdata;
    end
    if (req.rd) oam_q <= oam_mem[req.idx[OAM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_q <= TGT_NONE;
    end else if (req.rd) begin
      tgt_q <= req.tgt;
    end
  end

  always_comb begin
    case (tgt_q)
      TGT_NT:  rdata = nt_q;
      TGT_PAL: rdata = pal_q;
      TGT_OAM: rdata = oam_q;
      default: rdata = 8'd0;  // pattern area reads as zero
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrp_regs.sv =====
// Register file and item sequencer: decodes bus items, issues memory
// accesses, holds one finished result. Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrp_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        cmd,
  input  wire logic [2:0]        reg_index,
  input  wire logic [7:0]        wdata,
  input  wire logic [2:0]        status_flags,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              mirror_mode,
  input  wire logic              mem_clearing,
  output vrp_pkg::mem_req_t      mem_req,
  input  wire logic [7:0]        mem_rdata,
  input  wire logic              res_take,
  output logic                   res_valid,
  output vrp_pkg::res_t          res
);
  import vrp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state;
  logic            mirror;
  logic            inc32, inc32_next;      // step-by-32 bit of the control byte
  logic [2:0]      status, status_next;    // {overflow, sprite0, vblank}
  logic [7:0]      oam_addr, oam_addr_next;
  logic            toggle, toggle_next;
  logic [VA_W-1:0] temp, temp_next;
  logic [VA_W-1:0] cur, cur_next;
  logic [2:0]      fine_x, fine_x_next;
  logic [7:0]      rbuf, rbuf_next;
  logic            rd_data_q, rd_pal_q;
  logic [7:0]      rd_val;
  logic            accept, mem_op, res_load;
  vmap_t           map;

  assign in_stall  = mem_clearing || (state == ST_READ) || (res_valid && !res_take);
  assign accept    = in_valid && !in_stall;
  assign mem_op    = (cmd == CMD_READ) &&
                     ((reg_index == REG_OAM_DATA) || (reg_index == REG_DATA));
  assign res_load  = (accept && !mem_op) || (state == ST_READ);
  assign cfg_ready = 1'b1;
  assign map       = vram_map(cur, mirror);

  always_comb begin
    inc32_next    = inc32;
    status_next   = status;
    oam_addr_next = oam_addr;
    toggle_next   = toggle;
    temp_next     = temp;
    cur_next      = cur;
    fine_x_next   = fine_x;
    rbuf_next     = rbuf;
    rd_val        = 8'd0;
    mem_req       = '0;
    if (state == ST_READ) begin
      if (rd_data_q) begin
        rd_val    = rd_pal_q ? mem_rdata : rbuf;
        rbuf_next = mem_rdata;
        cur_next  = step_addr(cur, inc32);
      end else begin
        rd_val = mem_rdata;
      end
    end else if (accept) begin
      case (cmd)
        CMD_READ: begin
          case (reg_index)
            REG_STATUS: begin
              rd_val      = {status[0], status[1], status[2], rbuf[4:0]};
              status_next = {status[2:1], 1'b0};
              toggle_next = 1'b0;
            end
            REG_OAM_DATA: begin
              mem_req.rd  = 1'b1;
              mem_req.tgt = TGT_OAM;
              mem_req.idx = {{(NT_AW-OAM_AW){1'b0}}, oam_addr};
            end
            REG_DATA: begin
              mem_req.rd  = 1'b1;
              mem_req.tgt = map.tgt;
              mem_req.idx = map.idx;
            end
            default: ;
          endcase
        end
        CMD_WRITE: begin
          case (reg_index)
            REG_CTRL: begin
              inc32_next       = wdata[2];
              temp_next[11:10] = wdata[1:0];
            end
            REG_OAM_ADDR: oam_addr_next = wdata;
            REG_OAM_DATA: begin
              mem_req.wr    = 1'b1;
              mem_req.tgt   = TGT_OAM;
              mem_req.idx   = {{(NT_AW-OAM_AW){1'b0}}, oam_addr};
              mem_req.wdata = wdata;
            end
            REG_SCROLL: begin
              if (!toggle) begin
                fine_x_next    = wdata[2:0];
                temp_next[4:0] = wdata[7:3];
              end else begin
                temp_next[14:12] = wdata[2:0];
                temp_next[9:5]   = wdata[7:3];
              end
              toggle_next = !toggle;
            end
            REG_ADDR: begin
              if (!toggle) begin
                temp_next[14]   = 1'b0;
                temp_next[13:8] = wdata[5:0];
              end else begin
                temp_next[7:0] = wdata;
                cur_next       = {temp[14:8], wdata};
              end
              toggle_next = !toggle;
            end
            REG_DATA: begin
              mem_req.wr    = 1'b1;
              mem_req.tgt   = map.tgt;
              mem_req.idx   = map.idx;
              mem_req.wdata = wdata;
              cur_next      = step_addr(cur, inc32);
            end
            default: ;  // mask bits drive rendering only; status writes drop
          endcase
        end
        CMD_FLAGS: status_next = status | status_flags;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mirror    <= 1'b0;
      inc32     <= 1'b0;
      status    <= '0;
      oam_addr  <= '0;
      toggle    <= 1'b0;
      temp      <= '0;
      cur       <= '0;
      fine_x    <= '0;
      rbuf      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid) mirror <= mirror_mode;
      state     <= (accept && mem_op) ? ST_READ : ST_IDLE;
      inc32     <= inc32_next;
      status    <= status_next;
      oam_addr  <= oam_addr_next;
      toggle    <= toggle_next;
      temp      <= temp_next;
      cur       <= cur_next;
      fine_x    <= fine_x_next;
      rbuf      <= rbuf_next;
      res_valid <= res_load || (res_valid && !res_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_q <= (reg_index == REG_DATA);
      rd_pal_q  <= (map.tgt == TGT_PAL);
    end
    if (res_load) res <= {rd_val, cur_next, fine_x_next};
  end

endmodule

`default_nettype wire

// ===== rtl/core/video_register_port_with_vram_unit.sv =====
// Top level of the video register port: register sequencer, video
// memories and the output register. Depends on vrp_pkg, vrp_regs, vrp_mem.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake              | Payload
// --------+------------------------+---------------------------------------
// in      | in_valid / in_stall    | cmd, reg_index, wdata, status_flags
// out     | out_valid / out_stall  | rdata, vram_address, fine_scroll_x
// cfg     | cfg_valid / cfg_ready  | mirror_mode
//
// Bus writes, status-flag items and register reads load the holding register
// directly; reads of sprite attribute data and of the data register wait
// in a read state for the registered output of the synchronous memories.
// Reset (rst, synchronous) starts a sweep that zeroes the nametable,
// palette and sprite memories; in_stall stays high throughout, while cfg
// writes are taken as usual.
// One finished result waits in a holding register ahead of the output
// register, so a stalled output keeps the next item moving until both fill.

module video_register_port_with_vram_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  reg_index,
  input  wire logic [7:0]  wdata,
  input  wire logic [2:0]  status_flags,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       rdata,
  output logic [14:0]      vram_address,
  output logic [2:0]       fine_scroll_x,
  // mirroring register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        mirror_mode
);
  import vrp_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       mem_clearing;
  logic       res_valid;
  logic       res_take;
  res_t       res;

  vrp_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .reg_index    (reg_index),
    .wdata        (wdata),
    .status_flags (status_flags),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .mirror_mode  (mirror_mode),
    .mem_clearing (mem_clearing),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .res_take     (res_take),
    .res_valid    (res_valid),
    .res          (res)
  );

  vrp_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .rdata    (mem_rdata),
    .clearing (mem_clearing)
  );

  // advance the held result whenever the output register is empty or drains
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload while stalled; load only on a move from the holding stage
  always_ff @(posedge clk) begin
    if (res_take) begin
      rdata         <= res.rdata;
      vram_address  <= res.vaddr;
      fine_scroll_x <= res.fine_x;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrp_check.sv =====
// Port-level assertions for the video register port, bound to the top.
// Depends on vrp_pkg and video_register_port_with_vram_unit.
`timescale 1ns / 1ps
`default_nettype none

module vrp_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  cmd,
  input wire logic [2:0]  reg_index,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  rdata,
  input wire logic [14:0] vram_address,
  input wire logic [2:0]  fine_scroll_x
);
  import vrp_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rdata) &&
      $stable(vram_address) && $stable(fine_scroll_x))
    else $error("stalled result changed");

  // memory clearing keeps the input closed right after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input open during memory clear");

  // a data read closes the input while it waits for the memory
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == CMD_READ && reg_index == REG_DATA |=> in_stall)
    else $error("data read did not wait for memory");

  // a write into an empty output reaches out_valid through the holding and output registers
  a_write_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == CMD_WRITE && !out_valid |-> ##2 out_valid)
    else $error("write result missing");

endmodule

bind video_register_port_with_vram_unit vrp_check u_vrp_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .cmd           (cmd),
  .reg_index     (reg_index),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .rdata         (rdata),
  .vram_address  (vram_address),
  .fine_scroll_x (fine_scroll_x)
);

`default_nettype wire
